FILE: sv/abr_pkg.sv
// shared constants and types for the anchor box refine block
package abr_pkg;

	localparam int CoordW = 21;
	localparam int DeltaW = 16;
	localparam int OutW = 20;
	localparam int ScoreW = 16;
	localparam int MinW = 20;
	localparam logic [29:0] Ln2Q30 = 30'd744261118;
	localparam logic [30:0] Q30One = 31'h4000_0000;

	localparam logic [2:0] RegOffset = 3'd0;
	localparam logic [2:0] RegMaxLog = 3'd1;
	localparam logic [2:0] RegImgW = 3'd2;
	localparam logic [2:0] RegImgH = 3'd3;
	localparam logic [2:0] RegMinW = 3'd4;
	localparam logic [2:0] RegMinH = 3'd5;

	localparam logic signed [DeltaW-1:0] MaxLogReset = 16'sd16937;

	// one axis worth of pipeline payload
	typedef struct packed {
		logic signed [CoordW-1:0] lo;
		logic signed [22:0] size4;
		logic signed [DeltaW-1:0] shift;
		logic signed [DeltaW-1:0] d;
	} axis_in_t;

endpackage

FILE: sv/abr_axis.sv
// one-axis refine pipeline: exp of the clamped log delta, new corners, clamp, round
module abr_axis (
	input  logic clk,
	input  logic adv,
	input  abr_pkg::axis_in_t ax,
	input  logic off,
	input  logic [15:0] img,
	output logic [abr_pkg::OutW-1:0] olo,
	output logic [abr_pkg::OutW-1:0] ohi
);
	import abr_pkg::*;

	// stage 1: x = d * 2^18, k by reciprocal estimate
	logic signed [34:0] x_c;
	logic signed [34:0] x_s1;
	logic signed [5:0] k_s1;
	axis_in_t ax_s1;
	// k estimate: floor(x / ln2) via d*0x5c55 >> 26 (approx) then fix
	logic signed [33:0] kp_c;
	logic signed [5:0] ke_c;

	assign x_c = 35'(ax.d) <<< 18;
	assign kp_c = 34'(ax.d) * 34'sd23637;
	assign ke_c = 6'(kp_c >>> 26);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x_c;
			k_s1 <= ke_c;
			ax_s1 <= ax;
		end
	end

	// stage 2: r = x - k*ln2, corrected into [0, ln2)
	logic signed [36:0] r0_c;
	logic signed [36:0] r1_c;
	logic signed [5:0] k1_c;
	logic [29:0] r_s2;
	logic signed [5:0] k_s2;
	axis_in_t ax_s2;

	assign r0_c = 37'(x_s1) - 37'(k_s1) * 37'($signed({1'b0, Ln2Q30}));
	always_comb begin
		r1_c = r0_c;
		k1_c = k_s1;
		if (r0_c < 0) begin
			r1_c = r0_c + 37'($signed({1'b0, Ln2Q30}));
			k1_c = k_s1 - 6'sd1;
		end else if (r0_c >= 37'($signed({1'b0, Ln2Q30}))) begin
			r1_c = r0_c - 37'($signed({1'b0, Ln2Q30}));
			k1_c = k_s1 + 6'sd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2 <= r1_c[29:0];
			k_s2 <= k1_c;
			ax_s2 <= ax_s1;
		end
	end

	// horner stages: two register stages per step (multiply, then divide by n)
	logic [30:0] e_h [0:12];
	logic [29:0] r_h [0:12];
	logic signed [5:0] k_h [0:12];
	axis_in_t ax_h [0:12];

	assign e_h[0] = Q30One;
	assign r_h[0] = r_s2;
	assign k_h[0] = k_s2;
	assign ax_h[0] = ax_s2;

	for (genvar i = 0; i < 12; i++) begin : g_horner
		localparam int N = 12 - i;
		localparam int L = $clog2(N);
		// exact floor(p / n) for any 31 bit p by a rounded-up reciprocal
		localparam logic [31:0] M =
			32'(((64'd1 << (31 + L)) + 64'(N) - 64'd1) / 64'(N));
		logic [30:0] p_m;
		logic [29:0] r_m;
		logic signed [5:0] k_m;
		axis_in_t ax_m;
		logic [60:0] prod_c;
		logic [62:0] qp_c;
		logic [30:0] q_c;
		logic [30:0] e_n;
		logic [29:0] r_n;
		logic signed [5:0] k_n;
		axis_in_t ax_n;

		assign prod_c = 61'(r_h[i]) * 61'(e_h[i]);
		always_ff @(posedge clk) begin
			if (adv) begin
				p_m <= prod_c[60:30];
				r_m <= r_h[i];
				k_m <= k_h[i];
				ax_m <= ax_h[i];
			end
		end
		assign qp_c = 63'(p_m) * 63'(M);
		assign q_c = 31'(qp_c >> (31 + L));
		always_ff @(posedge clk) begin
			if (adv) begin
				e_n <= Q30One + q_c;
				r_n <= r_m;
				k_n <= k_m;
				ax_n <= ax_m;
			end
		end
		assign e_h[i+1] = e_n;
		assign r_h[i+1] = r_n;
		assign k_h[i+1] = k_n;
		assign ax_h[i+1] = ax_n;
	end

	// scale to Q.24
	logic [46:0] sc_c;
	logic [46:0] sc_a;
	logic [4:0] sh_c;
	always_comb begin
		sc_c = '0;
		sc_a = '0;
		sh_c = '0;
		if (k_h[12] >= 6'sd6) begin
			sc_c = 47'(e_h[12]) << 4'(k_h[12] - 6'sd6);
		end else begin
			sh_c = 5'(6'sd6 - k_h[12]);
			sc_a = 47'(e_h[12]) + (47'd1 << (sh_c - 5'd1));
			sc_c = sc_a >> sh_c;
		end
	end

	logic [46:0] sc_s3;
	axis_in_t ax_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			sc_s3 <= sc_c;
			ax_s3 <= ax_h[12];
		end
	end

	// products: half size and centre shift
	logic signed [71:0] half_c;
	logic signed [40:0] sft_c;
	logic signed [71:0] half_s4;
	logic signed [40:0] sft_s4;
	axis_in_t ax_s4;
	assign half_c = $signed({1'b0, sc_s3}) * 72'(ax_s3.size4);
	assign sft_c = 41'(ax_s3.shift) * 41'(ax_s3.size4);
	always_ff @(posedge clk) begin
		if (adv) begin
			half_s4 <= half_c;
			sft_s4 <= sft_c;
			ax_s4 <= ax_s3;
		end
	end

	// corners in Q.29
	logic signed [73:0] ctr_c;
	logic signed [73:0] a_s5;
	logic signed [73:0] b_s5;
	logic signed [73:0] offq;
	assign offq = off ? (74'sd16 <<< 25) : 74'sd0;
	assign ctr_c = (74'(ax_s4.lo) <<< 25) + (74'(ax_s4.size4) <<< 24) + (74'(sft_s4) <<< 13);
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s5 <= ctr_c - 74'(half_s4);
			b_s5 <= ctr_c + 74'(half_s4) - offq;
		end
	end

	// clamp and round
	logic signed [73:0] bound;
	logic signed [73:0] a_c;
	logic signed [73:0] b_c;
	logic [73:0] ar;
	logic [73:0] br;
	assign bound = ((74'($signed({1'b0, img})) <<< 4) - (off ? 74'sd16 : 74'sd0)) <<< 25;
	always_comb begin
		a_c = (a_s5 > bound) ? bound : a_s5;
		if (a_c < 0) a_c = '0;
		b_c = (b_s5 > bound) ? bound : b_s5;
		if (b_c < 0) b_c = '0;
		ar = $unsigned(a_c) + 74'd16777216;
		br = $unsigned(b_c) + 74'd16777216;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			olo <= ar[44:25];
			ohi <= br[44:25];
		end
	end
endmodule

FILE: sv/anchor_box_refine.sv
// anchor box refine top level: register file, input prep, two axis pipelines, size check
// One box is taken per clock when start is high; busy is always low, since the
// fixed-length pipeline never stalls and the receiver must take every result. A
// result appears on done together with its fields after the input prep and the
// exp unit: range reduction, a twelve-step Horner series with two stages per
// step, scaling, the corner products, clamping and the size check.
module anchor_box_refine (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [abr_pkg::CoordW-1:0] left,
	input  logic signed [abr_pkg::CoordW-1:0] top,
	input  logic signed [abr_pkg::CoordW-1:0] right,
	input  logic signed [abr_pkg::CoordW-1:0] bottom,
	input  logic signed [abr_pkg::DeltaW-1:0] shift_x,
	input  logic signed [abr_pkg::DeltaW-1:0] shift_y,
	input  logic signed [abr_pkg::DeltaW-1:0] log_scale_w,
	input  logic signed [abr_pkg::DeltaW-1:0] log_scale_h,
	input  logic [abr_pkg::ScoreW-1:0] score_in,
	output logic done,
	output logic [abr_pkg::OutW-1:0] out_left,
	output logic [abr_pkg::OutW-1:0] out_top,
	output logic [abr_pkg::OutW-1:0] out_right,
	output logic [abr_pkg::OutW-1:0] out_bottom,
	output logic [abr_pkg::ScoreW-1:0] score_out,
	output logic big_enough,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import abr_pkg::*;

	// s0 prep, s1, s2, 24 horner, s3, s4, s5, out reg, final check
	localparam int Latency = 32;

	logic off_q;
	logic signed [15:0] maxlog_q;
	logic [15:0] imgw_q;
	logic [15:0] imgh_q;
	logic [19:0] minw_q;
	logic [19:0] minh_q;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= 1'b1;
			maxlog_q <= MaxLogReset;
			imgw_q <= 16'd1024;
			imgh_q <= 16'd1024;
			minw_q <= '0;
			minh_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				RegOffset: off_q <= pwdata[0];
				RegMaxLog: maxlog_q <= pwdata[15:0];
				RegImgW: imgw_q <= pwdata[15:0];
				RegImgH: imgh_q <= pwdata[15:0];
				RegMinW: minw_q <= pwdata[19:0];
				RegMinH: minh_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			RegOffset: prdata = {31'd0, off_q};
			RegMaxLog: prdata = {16'd0, maxlog_q};
			RegImgW: prdata = {16'd0, imgw_q};
			RegImgH: prdata = {16'd0, imgh_q};
			RegMinW: prdata = {12'd0, minw_q};
			RegMinH: prdata = {12'd0, minh_q};
			default: prdata = '0;
		endcase
	end

	// input prep stage
	axis_in_t xin_c, yin_c, xin_s0, yin_s0;
	logic signed [22:0] offs;
	assign offs = off_q ? 23'sd16 : 23'sd0;
	always_comb begin
		xin_c.lo = left;
		xin_c.size4 = 23'(right) - 23'(left) + offs;
		xin_c.shift = shift_x;
		xin_c.d = (log_scale_w < maxlog_q) ? log_scale_w : maxlog_q;
		yin_c.lo = top;
		yin_c.size4 = 23'(bottom) - 23'(top) + offs;
		yin_c.shift = shift_y;
		yin_c.d = (log_scale_h < maxlog_q) ? log_scale_h : maxlog_q;
	end
	always_ff @(posedge clk) begin
		xin_s0 <= xin_c;
		yin_s0 <= yin_c;
	end

	logic [Latency-1:0] vld_q;
	logic [ScoreW-1:0] sc_q [0:Latency-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Latency-2:0], start};
	end
	always_ff @(posedge clk) begin
		sc_q[0] <= score_in;
		for (int i = 1; i < Latency; i++) sc_q[i] <= sc_q[i-1];
	end

	logic [OutW-1:0] x0, x1, y0, y1;
	abr_axis u_x (.clk, .adv(1'b1), .ax(xin_s0), .off(off_q), .img(imgw_q),
		.olo(x0), .ohi(x1));
	abr_axis u_y (.clk, .adv(1'b1), .ax(yin_s0), .off(off_q), .img(imgh_q),
		.olo(y0), .ohi(y1));

	// size check
	logic signed [21:0] bw_c, bh_c;
	assign bw_c = 22'($signed({1'b0, x1})) - 22'($signed({1'b0, x0})) + 22'(offs);
	assign bh_c = 22'($signed({1'b0, y1})) - 22'($signed({1'b0, y0})) + 22'(offs);
	always_ff @(posedge clk) begin
		out_left <= x0;
		out_right <= x1;
		out_top <= y0;
		out_bottom <= y1;
		big_enough <= ($signed({2'b0, minw_q}) <= bw_c) && ($signed({2'b0, minh_q}) <= bh_c);
	end
	assign score_out = sc_q[Latency-1];
	assign done = vld_q[Latency-1];

	a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start, Latency) && $past(arst_n, Latency) |-> done)
		else $error("result lost");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_left <= {imgw_q, 4'd0} && out_top <= {imgh_q, 4'd0})
		else $error("clamp broken");
endmodule
